// ----- hw/rtl/rbb_pkg.sv -----
// Shared types, constants and register map of the RGB 3x3 box blur.
`default_nettype none

package rbb_pkg;

  // Widths and defaults
  localparam int unsigned MAX_WIDTH_DEF = 8192;
  localparam int unsigned PIX_W         = 24;
  localparam int unsigned FW_W          = 14;
  localparam int unsigned FH_W          = 16;
  localparam int unsigned ROW_W         = 17;
  localparam int unsigned APB_DW        = 32;
  localparam int unsigned APB_AW        = 3;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 14'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;
  localparam int unsigned     MIN_DIM          = 3;

  // Register indexes (paddr bit 2)
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // floor(x / 9) == (x * 3641) >> 15 for every x below 32768
  localparam logic [11:0] DIV9_MUL   = 12'd3641;
  localparam int unsigned DIV9_SHIFT = 15;

  // Output queue occupancy when full
  localparam logic [1:0] QUEUE_FULL = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [8:0]       win_t;   // row*3 + column, column 0 oldest
  typedef logic [8:0][7:0]  chwin_t; // one colour channel of the window

  // Item leaving the position/control stage
  typedef struct packed {
    logic upd;     // item shifts the window and writes the line stores
    logic emit;    // item releases a result
    logic border;  // released pixel lies on the image border
    logic last;    // released pixel is the final one of the frame
  } item_t;

  // Result tags travelling alongside the arithmetic lanes
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
  } res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rbb_ctrl.sv -----
// Position counters, flush handling and result tagging for the box blur.
`default_nettype none

module rbb_ctrl #(
  parameter int unsigned MAX_WIDTH = rbb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned CW        = $clog2(MAX_WIDTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      move_i,
  input  wire logic                      in_valid_i,
  input  wire logic [rbb_pkg::PIX_W-1:0] pixel_in_i,
  input  wire logic                      drain_i,
  input  wire logic [rbb_pkg::FW_W-1:0]  frame_width_i,
  input  wire logic [rbb_pkg::FH_W-1:0]  frame_height_i,
  output logic [CW-1:0]                  rd_addr_o,
  output rbb_pkg::item_t                 item_o,
  output logic [CW-1:0]                  col_o,
  output rbb_pkg::pix_t                  cur_o
);

  localparam int unsigned WW = CW + 1;

  logic [CW-1:0]             in_col_q, in_col_d;
  logic [rbb_pkg::ROW_W-1:0] in_row_q, in_row_d;
  logic [CW-1:0]             out_col_q, out_col_d;
  logic [rbb_pkg::FH_W-1:0]  out_row_q, out_row_d;
  rbb_pkg::item_t            item_q, item_d;
  logic [CW-1:0]             col_q;
  rbb_pkg::pix_t             cur_q;

  logic [15:0]               fw_ext;
  logic [WW-1:0]             eff_w;
  logic [rbb_pkg::FH_W-1:0]  eff_h;
  logic                      accept, flushing, ignore, take, emit;
  logic                      col_end, out_col_end, out_row_end, border, last;

  // Clamp the configured frame size
  always_comb begin
    fw_ext = 16'(frame_width_i);
    if (fw_ext < 16'(rbb_pkg::MIN_DIM)) begin
      eff_w = WW'(rbb_pkg::MIN_DIM);
    end else if (fw_ext > 16'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_ext);
    end
    if (frame_height_i < rbb_pkg::FH_W'(rbb_pkg::MIN_DIM)) begin
      eff_h = rbb_pkg::FH_W'(rbb_pkg::MIN_DIM);
    end else begin
      eff_h = frame_height_i;
    end
  end

  // Item classification against the current position
  always_comb begin
    accept      = move_i && in_valid_i;
    flushing    = in_row_q >= rbb_pkg::ROW_W'(eff_h);
    ignore      = drain_i && !flushing;
    take        = accept && !ignore;
    emit        = (in_row_q >= rbb_pkg::ROW_W'(2)) ||
                  ((in_row_q == rbb_pkg::ROW_W'(1)) && (in_col_q != '0));
    col_end     = (WW'(in_col_q) + WW'(1)) >= eff_w;
    out_col_end = (WW'(out_col_q) + WW'(1)) >= eff_w;
    out_row_end = (rbb_pkg::ROW_W'(out_row_q) + rbb_pkg::ROW_W'(1)) >=
                  rbb_pkg::ROW_W'(eff_h);
    border      = (out_row_q == '0) || out_row_end || (out_col_q == '0) || out_col_end;
    last        = out_col_end && out_row_end;
  end

  // Counter update
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (take) begin
      if (col_end) begin
        in_col_d = '0;
        in_row_d = in_row_q + rbb_pkg::ROW_W'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (emit) begin
        if (last) begin
          in_col_d  = '0;
          in_row_d  = '0;
          out_col_d = '0;
          out_row_d = '0;
        end else if (out_col_end) begin
          out_col_d = '0;
          out_row_d = out_row_q + rbb_pkg::FH_W'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  // Tags for the next stage
  always_comb begin
    item_d.upd    = take;
    item_d.emit   = take && emit;
    item_d.border = border;
    item_d.last   = last;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      item_q    <= '0;
    end else if (move_i) begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      item_q    <= item_d;
    end
  end

  // Item payload: zero pixel while draining or flushing
  always_ff @(posedge clk_i) begin
    if (move_i) begin
      col_q <= in_col_q;
      cur_q <= (drain_i || flushing) ? '0 : pixel_in_i;
    end
  end

  assign rd_addr_o = in_col_q;
  assign item_o    = item_q;
  assign col_o     = col_q;
  assign cur_o     = cur_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rbb_window.sv -----
// Line store memory and 3x3 window registers of the box blur.
`default_nettype none

module rbb_window #(
  parameter int unsigned MAX_WIDTH = rbb_pkg::MAX_WIDTH_DEF,
  parameter int unsigned CW        = $clog2(MAX_WIDTH)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           move_i,
  input  wire logic [CW-1:0]  rd_addr_i,
  input  wire rbb_pkg::item_t item_i,
  input  wire logic [CW-1:0]  col_i,
  input  wire rbb_pkg::pix_t  cur_i,
  output rbb_pkg::win_t       win_o,
  output rbb_pkg::res_t       res_o
);

  localparam int unsigned LW = 2 * rbb_pkg::PIX_W;

  // Upper store in the high half, lower store in the low half
  logic [LW-1:0]  line_mem_q [MAX_WIDTH];
  logic [LW-1:0]  rd_data_q;
  logic           byp_hit_q;
  logic [LW-1:0]  byp_data_q;
  rbb_pkg::win_t  win_q;
  rbb_pkg::res_t  res_q;

  logic [LW-1:0]  fwd;
  rbb_pkg::pix_t  up, mid;
  logic [LW-1:0]  wr_data;

  // Read data, with the write of the same cycle forwarded
  always_comb begin
    fwd     = byp_hit_q ? byp_data_q : rd_data_q;
    up      = fwd[LW-1:rbb_pkg::PIX_W];
    mid     = fwd[rbb_pkg::PIX_W-1:0];
    wr_data = {mid, cur_i};
  end

  // Line store: one read and one write port
  always_ff @(posedge clk_i) begin
    if (move_i) begin
      rd_data_q <= line_mem_q[rd_addr_i];
    end
    if (move_i && item_i.upd) begin
      line_mem_q[col_i] <= wr_data;
    end
  end

  // Read-during-write at the same column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else if (move_i) begin
      byp_hit_q <= item_i.upd && (col_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_i) begin
      byp_data_q <= wr_data;
    end
  end

  // Window shift: new column enters at the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      res_q <= '0;
    end else if (move_i) begin
      res_q.emit   <= item_i.emit;
      res_q.border <= item_i.border;
      res_q.last   <= item_i.last;
      if (item_i.upd) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]     <= win_q[r*3 + 1];
          win_q[r*3 + 1] <= win_q[r*3 + 2];
        end
        win_q[2] <= up;
        win_q[5] <= mid;
        win_q[8] <= cur_i;
      end
    end
  end

  assign win_o = win_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rbb_lane.sv -----
// One colour channel lane: nine-sample sum and divide by nine.
`default_nettype none

module rbb_lane (
  input  wire logic            clk_i,
  input  wire logic            move_i,
  input  wire rbb_pkg::chwin_t px_i,
  output logic [7:0]           quot_o
);

  logic [2:0][9:0] row_sum_q;
  logic [11:0]     total_q;
  logic [7:0]      quot_q;
  logic [23:0]     prod;

  // Reciprocal multiply for the divide
  assign prod = 24'(total_q) * 24'(rbb_pkg::DIV9_MUL);

  // Row sums, total, quotient
  always_ff @(posedge clk_i) begin
    if (move_i) begin
      for (int r = 0; r < 3; r++) begin
        row_sum_q[r] <= 10'(px_i[r*3]) + 10'(px_i[r*3 + 1]) + 10'(px_i[r*3 + 2]);
      end
      total_q <= 12'(row_sum_q[0]) + 12'(row_sum_q[1]) + 12'(row_sum_q[2]);
      quot_q  <= prod[rbb_pkg::DIV9_SHIFT +: 8];
    end
  end

  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_box_blur_3x3.sv -----
// Top level of the RGB 3x3 box blur: config port, lanes, merge and output queue.
//
//   Channel   Direction  Handshake                 Payload
//   in        sink       in_valid_i / in_ready_o   pixel_in_i, drain_i
//   out       source     out_valid_o / out_ready_i pixel_out_o, frame_end_o
//   config    APB slave  psel/penable/pwrite       paddr, pwdata, prdata
//
// One item per clock while the output queue has room.
// in_ready_o drops only while the two-entry output queue is full.
// The line stores are one memory with one read and one write per cycle.
// Reset clears counters, window and queue; line stores need no clearing.
`default_nettype none

module rgb_box_blur_3x3 #(
  parameter int unsigned MAX_WIDTH = rbb_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [rbb_pkg::PIX_W-1:0]  pixel_in_i,
  input  wire logic                       drain_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [rbb_pkg::PIX_W-1:0]       pixel_out_o,
  output logic                            frame_end_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [rbb_pkg::APB_AW-1:0] paddr,
  input  wire logic [rbb_pkg::APB_DW-1:0] pwdata,
  output logic [rbb_pkg::APB_DW-1:0]      prdata,
  output logic                            pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [rbb_pkg::FW_W-1:0] frame_width_q;
  logic [rbb_pkg::FH_W-1:0] frame_height_q;

  logic                     move;
  logic [CW-1:0]            rd_addr;
  rbb_pkg::item_t           item;
  logic [CW-1:0]            col;
  rbb_pkg::pix_t            cur;
  rbb_pkg::win_t            win;
  rbb_pkg::res_t            res2;
  rbb_pkg::res_t            res3_q, res4_q, res5_q;
  rbb_pkg::pix_t            ctr3_q, ctr4_q, ctr5_q;
  rbb_pkg::chwin_t          lane_px [3];
  logic [2:0][7:0]          quot;

  rbb_pkg::pix_t            q_pix_q [2];
  logic                     q_end_q [2];
  logic                     wr_ptr_q, rd_ptr_q;
  logic [1:0]               cnt_q;
  logic                     push, pop;
  rbb_pkg::pix_t            push_pix;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= rbb_pkg::FRAME_WIDTH_RST;
      frame_height_q <= rbb_pkg::FRAME_HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        rbb_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[rbb_pkg::FW_W-1:0];
        rbb_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[rbb_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (paddr[2])
      rbb_pkg::REG_FRAME_WIDTH:  prdata = rbb_pkg::APB_DW'(frame_width_q);
      rbb_pkg::REG_FRAME_HEIGHT: prdata = rbb_pkg::APB_DW'(frame_height_q);
      default:                   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Whole pipeline advances while the output queue has room
  assign move       = (cnt_q != rbb_pkg::QUEUE_FULL);
  assign in_ready_o = move;

  rbb_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .move_i         (move),
    .in_valid_i     (in_valid_i),
    .pixel_in_i     (pixel_in_i),
    .drain_i        (drain_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .rd_addr_o      (rd_addr),
    .item_o         (item),
    .col_o          (col),
    .cur_o          (cur)
  );

  rbb_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .CW        (CW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .move_i    (move),
    .rd_addr_i (rd_addr),
    .item_i    (item),
    .col_i     (col),
    .cur_i     (cur),
    .win_o     (win),
    .res_o     (res2)
  );

  // Split the window into channel lanes
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        lane_px[ch][k] = win[k][8*ch +: 8];
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    rbb_lane u_lane (
      .clk_i  (clk_i),
      .move_i (move),
      .px_i   (lane_px[ch]),
      .quot_o (quot[ch])
    );
  end

  // Tags and centre pixel follow the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res3_q <= '0;
      res4_q <= '0;
      res5_q <= '0;
    end else if (move) begin
      res3_q <= res2;
      res4_q <= res3_q;
      res5_q <= res4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      ctr3_q <= win[4];
      ctr4_q <= ctr3_q;
      ctr5_q <= ctr4_q;
    end
  end

  // Merge: border pixels copy the centre, others take the lane quotients
  assign push_pix = res5_q.border ? ctr5_q : {quot[2], quot[1], quot[0]};
  assign push     = move && res5_q.emit;
  assign pop      = out_valid_o && out_ready_i;

  // Two-entry output queue
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_pix_q[wr_ptr_q] <= push_pix;
      q_end_q[wr_ptr_q] <= res5_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign pixel_out_o = q_pix_q[rd_ptr_q];
  assign frame_end_o = q_end_q[rd_ptr_q];

  // The queue never takes a transfer while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && (cnt_q == rbb_pkg::QUEUE_FULL)))
    else $error("push into full output queue");

  // Empty and full queues have matching pointers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cnt_q == '0) || (cnt_q == rbb_pkg::QUEUE_FULL)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("output queue pointers out of step");

  // The final pixel of a frame is always a border pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res5_q.emit && res5_q.last) |-> res5_q.border)
    else $error("frame end tagged on an interior pixel");

  // A result tag only enters the lane stages from the window stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res3_q.emit) |-> $past(res2.emit))
    else $error("result tag appeared without a source item");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for the RGB 3x3 box blur: stimulus, prediction and result checks.
`timescale 1ns / 1ps

module testbench;
  import rbb_pkg::*;

  localparam int unsigned CLK_PERIOD    = 20;
  localparam int unsigned RESET_CYCLES  = 4;
  localparam int unsigned GAP_MAX       = 12;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned HOLD_EVERY    = 400;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned RANDOM_ITEMS  = 1800;
  localparam int unsigned MAX_REPORTS   = 50;
  localparam int unsigned BLUR_TAPS     = 9;

  // Directed 3x3 frame, raster order
  localparam logic [0:8][PIX_W-1:0] CORNER_FRAME = {
    24'hFFFFFF, 24'h000000, 24'h0000FF,
    24'h00FF00, 24'h123456, 24'hFF0000,
    24'hFFFFFF, 24'hFFFFFF, 24'h000001
  };

  typedef struct {
    pix_t        pixel;
    logic        drain;
    int unsigned gap;
  } feed_item_t;

  typedef struct {
    pix_t pixel;
    logic frame_end;
  } blur_result_t;

  // DUT ports
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  pix_t              pixel_in_i  = '0;
  logic              drain_i     = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  pix_t              pixel_out_o;
  logic              frame_end_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Stimulus and scoreboard state
  feed_item_t   pixel_feed [$];
  blur_result_t blur_expected [$];
  feed_item_t   staged;
  bit           have_staged   = 1'b0;
  bit           in_busy       = 1'b0;
  int unsigned  gap_left      = 0;
  bit           in_xfer       = 1'b0;
  bit           out_xfer      = 1'b0;
  bit           send_idle_en  = 1'b1;
  bit           recv_stall_en = 1'b1;
  bit           flat_frame    = 1'b0;
  int unsigned  effective_fed = 0;
  int unsigned  mismatches    = 0;
  int unsigned  results_seen  = 0;
  int unsigned  quiet_cycles  = 0;
  int unsigned  stall_left    = 0;
  int unsigned  hold_left     = 0;
  int unsigned  rx_count      = 0;

  // Predictor state: configuration shadow, line stores, window, positions
  logic [FW_W-1:0]  cfg_width  = FRAME_WIDTH_RST;
  logic [FH_W-1:0]  cfg_height = FRAME_HEIGHT_RST;
  pix_t             upper_row [MAX_WIDTH_DEF] = '{default: '0};
  pix_t             lower_row [MAX_WIDTH_DEF] = '{default: '0};
  pix_t             win [9] = '{default: '0};
  logic [12:0]      in_col  = '0;
  logic [ROW_W-1:0] in_row  = '0;
  logic [12:0]      out_col = '0;
  logic [ROW_W-1:0] out_row = '0;

  blur_result_t oldest;

  rgb_box_blur_3x3 uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_in_i  (pixel_in_i),
    .drain_i     (drain_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .frame_end_o (frame_end_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic int unsigned eff_width();
    if (cfg_width < MIN_DIM) return MIN_DIM;
    if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height < MIN_DIM) return MIN_DIM;
    return cfg_height;
  endfunction

  // Advance the blur by one accepted item and queue the pixel it releases, if any
  task automatic blur_predict(input pix_t px, input logic drn);
    int unsigned  w, h, sum;
    bit           flushing, emits, border, is_last;
    pix_t         cur, avg;
    blur_result_t res;
    w = eff_width();
    h = eff_height();
    flushing = (in_row >= h);
    // a drain inside the frame does nothing
    if (drn && !flushing) return;
    cur = (drn || flushing) ? '0 : px;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = upper_row[in_col];
    win[5] = lower_row[in_col];
    win[8] = cur;
    upper_row[in_col] = lower_row[in_col];
    lower_row[in_col] = cur;
    emits = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= w) begin
      in_col = '0;
      in_row++;
    end else begin
      in_col++;
    end
    if (!emits) return;
    border = out_row == 0 || out_row + 1 >= h || out_col == 0 || out_col + 1 >= w;
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int k = 0; k < BLUR_TAPS; k++) sum += win[k][8*ch +: 8];
      avg[8*ch +: 8] = 8'(sum / BLUR_TAPS);
    end
    is_last = (out_col + 1 >= w) && (out_row + 1 >= h);
    res.pixel = border ? win[4] : avg;
    res.frame_end = is_last;
    blur_expected.push_back(res);
    if (is_last) begin
      in_col = '0;
      in_row = '0;
      out_col = '0;
      out_row = '0;
    end else if (out_col + 1 >= w) begin
      out_col = '0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  // APB read of one register, compared on its implemented bits
  task automatic reg_check(input logic idx, input logic [APB_DW-1:0] want);
    logic [APB_DW-1:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_FRAME_WIDTH) begin
      if (rd[FW_W-1:0] !== want[FW_W-1:0])
        report_mismatch($sformatf("frame_width reads %0d, wrote %0d",
                                  rd[FW_W-1:0], want[FW_W-1:0]));
    end else begin
      if (rd[FH_W-1:0] !== want[FH_W-1:0])
        report_mismatch($sformatf("frame_height reads %0d, wrote %0d",
                                  rd[FH_W-1:0], want[FH_W-1:0]));
    end
  endtask

  // APB write, shadow update, then read-back
  task automatic reg_write(input logic idx, input logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FRAME_WIDTH) cfg_width = data[FW_W-1:0];
    else cfg_height = data[FH_W-1:0];
    reg_check(idx, (idx == REG_FRAME_WIDTH) ? APB_DW'(cfg_width) : APB_DW'(cfg_height));
  endtask

  // Both dimension registers; unused upper data bits are sometimes junk
  task automatic write_frame_size(input int unsigned raw_w, input int unsigned raw_h);
    logic [APB_DW-1:0] data;
    data = $urandom_range(0, 1) ? $urandom() : '0;
    data[FW_W-1:0] = raw_w[FW_W-1:0];
    reg_write(REG_FRAME_WIDTH, data);
    data = $urandom_range(0, 1) ? $urandom() : '0;
    data[FH_W-1:0] = raw_h[FH_W-1:0];
    reg_write(REG_FRAME_HEIGHT, data);
  endtask

  function automatic pix_t random_pixel();
    pix_t px;
    if (flat_frame) return $urandom_range(0, 1) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
    for (int ch = 0; ch < 3; ch++) begin
      case ($urandom_range(0, 3))
        0:       px[8*ch +: 8] = 8'hFF;
        1:       px[8*ch +: 8] = 8'h00;
        default: px[8*ch +: 8] = 8'($urandom());
      endcase
    end
    return px;
  endfunction

  task automatic queue_item(input pix_t px, input logic drn);
    feed_item_t it;
    it.pixel = px;
    it.drain = drn;
    it.gap = send_idle_en ? $urandom_range(0, GAP_MAX) : 0;
    pixel_feed.push_back(it);
  endtask

  // Whole rows of pixels, with the odd ignored drain mixed in
  task automatic queue_rows(input int unsigned rows, input int unsigned w);
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        if ($urandom_range(0, 19) == 0) queue_item(random_pixel(), 1'b1);
        queue_item(random_pixel(), 1'b0);
        effective_fed++;
      end
    end
  endtask

  // width+1 flush items; some are pixels, which count as drains here
  task automatic queue_flush(input int unsigned w);
    for (int unsigned i = 0; i <= w; i++) begin
      queue_item(random_pixel(), $urandom_range(0, 7) != 0);
      effective_fed++;
    end
  endtask

  // Everything sent, every result back, and the pipeline given time to empty
  task automatic wait_idle();
    while (pixel_feed.size() != 0 || have_staged || in_busy || blur_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_frame(input int unsigned raw_w, input int unsigned raw_h);
    wait_idle();
    write_frame_size(raw_w, raw_h);
    queue_rows(eff_height(), eff_width());
    queue_flush(eff_width());
  endtask

  // Sender: one item per transfer, gap taken before each item
  always @(negedge clk_i) begin
    if (in_busy && in_xfer) in_busy = 1'b0;
    if (!in_busy) begin
      if (!have_staged && pixel_feed.size() != 0) begin
        staged = pixel_feed.pop_front();
        have_staged = 1'b1;
        gap_left = staged.gap;
      end
      if (have_staged) begin
        if (gap_left == 0) begin
          pixel_in_i <= staged.pixel;
          drain_i    <= staged.drain;
          in_busy = 1'b1;
          have_staged = 1'b0;
        end else begin
          gap_left--;
        end
      end
    end
    in_valid_i <= in_busy;
  end

  // Receiver: random stall per result, plus a long hold-off now and then
  always @(negedge clk_i) begin
    if (out_xfer) begin
      rx_count++;
      stall_left = recv_stall_en ? $urandom_range(0, GAP_MAX) : 0;
      if (rx_count % HOLD_EVERY == HOLD_EVERY / 2) hold_left = HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left--;
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_ready_i <= (hold_left == 0 && stall_left == 0);
  end

  // Monitor: predict on input transfers, check on output transfers
  always @(posedge clk_i) begin
    in_xfer  <= in_valid_i & in_ready_o;
    out_xfer <= out_valid_o & out_ready_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) blur_predict(pixel_in_i, drain_i);
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (blur_expected.size() == 0) begin
          report_mismatch($sformatf("result %0d unexpected: pixel %h frame_end %b",
                                    results_seen, pixel_out_o, frame_end_o));
        end else begin
          oldest = blur_expected.pop_front();
          if (pixel_out_o !== oldest.pixel)
            report_mismatch($sformatf("result %0d pixel_out %h, want %h",
                                      results_seen, pixel_out_o, oldest.pixel));
          if (frame_end_o !== oldest.frame_end)
            report_mismatch($sformatf("result %0d frame_end %b, want %b",
                                      results_seen, frame_end_o, oldest.frame_end));
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    int unsigned w, h, raw_w, raw_h, split_row;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    reg_check(REG_FRAME_WIDTH, APB_DW'(FRAME_WIDTH_RST));
    reg_check(REG_FRAME_HEIGHT, APB_DW'(FRAME_HEIGHT_RST));

    // Directed: smallest frame, extreme pixels, drains in and after the frame
    write_frame_size(MIN_DIM, MIN_DIM);
    queue_item(24'h5A5A5A, 1'b1);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) queue_item(24'hA5A5A5, 1'b1);
      queue_item(CORNER_FRAME[i], 1'b0);
    end
    queue_item(24'h000000, 1'b1);
    queue_item(24'hABCDEF, 1'b0);
    queue_item(24'hFFFFFF, 1'b1);
    queue_item(24'hFFFFFF, 1'b1);
    queue_item(24'h00FFFF, 1'b1);

    // Random frames, mostly small, some resized part way through
    while (effective_fed < RANDOM_ITEMS) begin
      wait_idle();
      send_idle_en  = ($urandom_range(0, 3) != 0);
      recv_stall_en = ($urandom_range(0, 3) != 0);
      flat_frame    = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0:       raw_w = $urandom_range(0, MIN_DIM - 1);
        1:       raw_w = $urandom_range(13, 40);
        default: raw_w = $urandom_range(MIN_DIM, 12);
      endcase
      raw_h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MIN_DIM - 1)
                                          : $urandom_range(MIN_DIM, 8);
      write_frame_size(raw_w, raw_h);
      w = eff_width();
      h = eff_height();
      split_row = ($urandom_range(0, 6) == 0) ? $urandom_range(1, h - 1) : 0;
      if (split_row != 0) begin
        // stop at a row boundary, narrow the row and change the height
        queue_rows(split_row, w);
        wait_idle();
        w = $urandom_range(MIN_DIM, w);
        h = $urandom_range((split_row + 1 > MIN_DIM) ? split_row + 1 : MIN_DIM,
                           split_row + 6);
        write_frame_size(w, h);
        queue_rows(h - split_row, w);
      end else begin
        queue_rows(h, w);
      end
      queue_flush(w);
      repeat ($urandom_range(0, 2)) queue_item(random_pixel(), 1'b1);
    end

    // Register extremes read back, then small frames at full rate
    wait_idle();
    send_idle_en  = 1'b0;
    recv_stall_en = 1'b0;
    flat_frame    = 1'b0;
    write_frame_size({FW_W{1'b1}}, {FH_W{1'b1}});
    run_frame(MIN_DIM, MIN_DIM);
    run_frame(12, 4);

    wait_idle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/rbb_pkg.sv
hw/rtl/rbb_ctrl.sv
hw/rtl/rbb_window.sv
hw/rtl/rbb_lane.sv
hw/rtl/rgb_box_blur_3x3.sv
sim/testbench.sv
